### src/tie_pkg.sv
// Shared types, constants and tables for the tiny ISA execute unit.
package tie_pkg;

  // Storage sizes
  localparam int unsigned MEM_DEPTH   = 256;
  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned REG_AW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_DATA_W-1:0] MISS_CYCLES_RST = 8'd50;
  localparam logic [CFG_DATA_W-1:0] HIT_CYCLES_RST  = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_CYCLES = 1'b0,
    CFG_HIT_CYCLES  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_CMP = 3'd2,
    OP_JE  = 3'd3,
    OP_JMP = 3'd4,
    OP_LD  = 3'd5,
    OP_ST  = 3'd6
  } op_e;

  // Input request as seen on the port
  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        dest_reg;
    logic [2:0]        src_reg;
    logic              use_immediate;
    logic signed [7:0] immediate;
    logic [7:0]        jump_address;
  } tie_in_t;

  // Result as seen on the port
  typedef struct packed {
    logic              jump_taken;
    logic [7:0]        jump_target;
    logic              mem_hit;
    logic signed [7:0] written_value;
    logic [31:0]       instr_total;
    logic [31:0]       cycle_total;
    logic [31:0]       hit_total;
    logic [31:0]       load_store_total;
  } tie_out_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e               op;
    logic              known;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rs;
    logic              rd_ok;
    logic              rs_ok;
    logic              use_imm;
    logic [7:0]        imm;
    logic [7:0]        target;
  } tie_cmd_t;

  // Register value to memory index (value modulo the memory depth)
  typedef logic [MEM_AW-1:0] addr_map_t [256];

  function automatic addr_map_t build_addr_map();
    addr_map_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = MEM_AW'(i % MEM_DEPTH);
    end
    return m;
  endfunction

  localparam addr_map_t ADDR_MAP = build_addr_map();

endpackage

### src/tiny_isa_execute_unit_top.sv
// Top level of the tiny ISA execute unit: front end, command queue, back end.
// Each request carries one decoded instruction and yields exactly one result.
// After the input handshake a request is stored in the two-entry command
// queue and then executes into the result register, which drives the output.
// The unit sustains one instruction per cycle while results are taken; the
// single result register and the queue depth let the input run three
// requests ahead while results stall.
// The data memory is read in the execute cycle and its registered output
// feeds the result, with the pending register write forwarded to the next
// instruction. Running totals in a result count up to and including that
// instruction. Configuration writes take effect at once and are meant for
// idle periods.
module tiny_isa_execute_unit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tie_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tie_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tie_pkg::tie_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tie_pkg::tie_out_t              out_data_o
);
  import tie_pkg::*;

  logic     fe_valid, fe_ready;
  tie_cmd_t fe_cmd;
  logic     be_valid, be_ready;
  tie_cmd_t be_cmd;

  tie_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  tie_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_cmd)
  );

  tie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/tie_front.sv
// Front end: accepts instruction requests and classifies them for the queue.
module tie_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tie_pkg::tie_in_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output tie_pkg::tie_cmd_t cmd_o
);
  import tie_pkg::*;

  // Pass the handshake straight to the queue
  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  // Decode opcode and check register numbers
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = op_e'(in_data_i.op);
    cmd_o.known   = (in_data_i.op <= 3'(OP_ST));
    cmd_o.rd      = in_data_i.dest_reg[REG_AW-1:0];
    cmd_o.rs      = in_data_i.src_reg[REG_AW-1:0];
    cmd_o.rd_ok   = (int'(in_data_i.dest_reg) < NUM_REGS);
    cmd_o.rs_ok   = (int'(in_data_i.src_reg) < NUM_REGS);
    cmd_o.use_imm = in_data_i.use_immediate;
    cmd_o.imm     = in_data_i.immediate;
    cmd_o.target  = in_data_i.jump_address;
  end

endmodule

### src/tie_queue.sv
// Short command queue between the front end and the execute back end.
module tie_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  tie_pkg::tie_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output tie_pkg::tie_cmd_t pop_data_o
);
  import tie_pkg::*;

  tie_cmd_t              slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]   count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/tie_back.sv
// Back end: executes commands against registers, data memory and counters.
module tie_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tie_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tie_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  tie_pkg::tie_cmd_t                   cmd_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tie_pkg::tie_out_t                   out_data_o
);
  import tie_pkg::*;

  // Configuration
  logic [7:0] miss_cycles_q, hit_cycles_q;

  // Architectural state
  logic [7:0]           regs_q [NUM_REGS];
  logic [7:0]           data_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] written_q, visited_q;
  logic                 eq_q, eq_d;
  logic [31:0]          instr_q, cycle_q, hit_cnt_q, ldst_q;
  logic [31:0]          instr_d, cycle_d, hit_cnt_d, ldst_d;

  // Result stage
  logic              s2_valid_q;
  logic              s2_taken_q;
  logic [7:0]        s2_target_q;
  logic              s2_hit_q;
  logic              s2_wr_q;
  logic [REG_AW-1:0] s2_rd_q;
  logic              s2_ld_q;
  logic [7:0]        s2_val_q;
  logic [7:0]        mem_rdata_q;
  logic              mem_vld_q;

  // Execute-side signals
  logic              advance, out_fire;
  logic [7:0]        ld_data, s2_wval;
  logic [7:0]        fwd_regs [NUM_REGS];
  logic [7:0]        rd_val, rs_val, sum;
  logic              taken, hit, wr, is_ld, is_st;
  logic [7:0]        target, val;
  logic [MEM_AW-1:0] addr;

  assign out_fire    = s2_valid_q && out_ready_i;
  assign advance     = cmd_valid_i && (!s2_valid_q || out_ready_i);
  assign cmd_ready_o = !s2_valid_q || out_ready_i;

  // Load data: a never-written entry reads as zero
  assign ld_data = mem_vld_q ? mem_rdata_q : '0;
  assign s2_wval = s2_ld_q ? ld_data : s2_val_q;

  // Forward the pending register write of the result stage
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      fwd_regs[i] = (s2_valid_q && s2_wr_q && s2_rd_q == REG_AW'(i)) ? s2_wval : regs_q[i];
    end
  end

  assign rd_val = cmd_i.rd_ok ? fwd_regs[cmd_i.rd] : '0;
  assign rs_val = cmd_i.rs_ok ? fwd_regs[cmd_i.rs] : '0;
  assign sum    = rd_val + (cmd_i.use_imm ? cmd_i.imm : rs_val);

  // Execute one command
  always_comb begin
    taken  = 1'b0;
    target = '0;
    wr     = 1'b0;
    val    = '0;
    is_ld  = 1'b0;
    is_st  = 1'b0;
    eq_d   = eq_q;
    if (cmd_i.known) begin
      unique case (cmd_i.op)
        OP_MOV: begin
          wr  = cmd_i.rd_ok;
          val = cmd_i.rd_ok ? cmd_i.imm : '0;
        end
        OP_ADD: begin
          wr  = cmd_i.rd_ok;
          val = cmd_i.rd_ok ? sum : '0;
        end
        OP_CMP: begin
          eq_d = (rd_val == rs_val);
        end
        OP_JE: begin
          if (eq_q) begin
            taken  = 1'b1;
            target = cmd_i.target;
            eq_d   = 1'b0;
          end
        end
        OP_JMP: begin
          taken  = 1'b1;
          target = cmd_i.target;
        end
        OP_LD: begin
          is_ld = 1'b1;
          wr    = cmd_i.rd_ok;
        end
        OP_ST: begin
          is_st = 1'b1;
          val   = rs_val;
        end
        default: begin
          taken = 1'b0;
        end
      endcase
    end
  end

  assign addr = ADDR_MAP[is_ld ? rs_val : rd_val];
  assign hit  = (is_ld || is_st) && visited_q[addr];

  // Update running totals
  always_comb begin
    instr_d   = instr_q;
    cycle_d   = cycle_q;
    hit_cnt_d = hit_cnt_q;
    ldst_d    = ldst_q;
    if (cmd_i.known) begin
      instr_d = instr_q + 32'd1;
      if (is_ld || is_st) begin
        ldst_d  = ldst_q + 32'd1;
        cycle_d = cycle_q + 32'(hit ? hit_cycles_q : miss_cycles_q);
        if (hit) begin
          hit_cnt_d = hit_cnt_q + 32'd1;
        end
      end else begin
        cycle_d = cycle_q + 32'd1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_cycles_q <= MISS_CYCLES_RST;
      hit_cycles_q  <= HIT_CYCLES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MISS_CYCLES: miss_cycles_q <= cfg_wdata_i;
        CFG_HIT_CYCLES:  hit_cycles_q  <= cfg_wdata_i;
        default:         miss_cycles_q <= miss_cycles_q;
      endcase
    end
  end

  // Commit flag, counters, tracking bits and the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q       <= 1'b0;
      instr_q    <= '0;
      cycle_q    <= '0;
      hit_cnt_q  <= '0;
      ldst_q     <= '0;
      written_q  <= '0;
      visited_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        eq_q      <= eq_d;
        instr_q   <= instr_d;
        cycle_q   <= cycle_d;
        hit_cnt_q <= hit_cnt_d;
        ldst_q    <= ldst_d;
        if (is_ld || is_st) begin
          visited_q[addr] <= 1'b1;
        end
        if (is_st) begin
          written_q[addr] <= 1'b1;
        end
        s2_valid_q <= 1'b1;
      end else if (out_fire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_taken_q  <= taken;
      s2_target_q <= target;
      s2_hit_q    <= hit;
      s2_wr_q     <= wr;
      s2_rd_q     <= cmd_i.rd;
      s2_ld_q     <= is_ld;
      s2_val_q    <= val;
    end
  end

  // Data memory: write on store, registered read on load
  always_ff @(posedge clk_i) begin
    if (advance && is_st) begin
      data_mem[addr] <= rs_val;
    end
    if (advance && is_ld) begin
      mem_rdata_q <= data_mem[addr];
      mem_vld_q   <= written_q[addr];
    end
  end

  // Retire register writes as results are taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (out_fire && s2_wr_q) begin
      regs_q[s2_rd_q] <= s2_wval;
    end
  end

  // Drive the result
  assign out_valid_o = s2_valid_q;
  always_comb begin
    out_data_o                  = '0;
    out_data_o.jump_taken       = s2_taken_q;
    out_data_o.jump_target      = s2_target_q;
    out_data_o.mem_hit          = s2_hit_q;
    out_data_o.written_value    = s2_ld_q ? (s2_wr_q ? ld_data : '0) : s2_val_q;
    out_data_o.instr_total      = instr_q;
    out_data_o.cycle_total      = cycle_q;
    out_data_o.hit_total        = hit_cnt_q;
    out_data_o.load_store_total = ldst_q;
  end

endmodule

### src/tie_checker.sv
// Port-level checks for the tiny ISA execute unit, bound to the top level.
module tie_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input tie_pkg::tie_out_t              out_data_o
);
  import tie_pkg::*;

  logic        have_prev_q;
  logic [31:0] prev_instr_q, prev_hit_q, prev_ldst_q;

  // Remember totals of the last result taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_instr_q <= '0;
      prev_hit_q   <= '0;
      prev_ldst_q  <= '0;
    end else if (out_valid_o && out_ready_i) begin
      have_prev_q  <= 1'b1;
      prev_instr_q <= out_data_o.instr_total;
      prev_hit_q   <= out_data_o.hit_total;
      prev_ldst_q  <= out_data_o.load_store_total;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Drop the target when no jump is taken
  a_no_jump_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.jump_taken |-> out_data_o.jump_target == 8'd0)
    else $error("jump target set without a taken jump");

  // Advance the instruction total by at most one per result
  a_instr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_prev_q |->
      out_data_o.instr_total == prev_instr_q ||
      out_data_o.instr_total == prev_instr_q + 32'd1)
    else $error("instruction total skipped");

  // A hit counts as one load/store and one hit
  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_prev_q && out_data_o.mem_hit |->
      out_data_o.load_store_total == prev_ldst_q + 32'd1 &&
      out_data_o.hit_total == prev_hit_q + 32'd1)
    else $error("hit not reflected in totals");

  // Accept requests again after the result side was ready to take a result
  a_ready_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_ready_i) && $past(rst_ni) |-> in_ready_o)
    else $error("input blocked while output drains");

endmodule

bind tiny_isa_execute_unit_top tie_checker u_tie_checker (.*);

### tb/sv/tie_exec_checker.sv
// Result checker for the tiny ISA execute unit: predicts each result and compares it.
module tie_exec_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tie_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tie_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  tie_pkg::tie_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  tie_pkg::tie_out_t              out_data_i,
  output int                             pending_o,
  output int                             fail_count_o,
  output int                             results_checked_o,
  output int                             jumps_taken_o,
  output int                             mem_hits_o
);
  import tie_pkg::*;

  // Architectural state of the predicted machine
  logic [7:0]  gpr     [NUM_REGS];
  logic [7:0]  dmem    [MEM_DEPTH];
  logic        touched [MEM_DEPTH];
  logic        eq_flag;
  logic [31:0] n_instr;
  logic [31:0] n_cycles;
  logic [31:0] n_hits;
  logic [31:0] n_ldst;
  logic [7:0]  miss_cost;
  logic [7:0]  hit_cost;

  // Results predicted but not yet seen on the output
  tie_out_t expected_results[$];

  int n_fail     = 0;
  int n_checked  = 0;
  int n_taken    = 0;
  int n_hit_seen = 0;

  // Read a register; numbers past the register file read as zero
  function automatic logic [7:0] read_gpr(input logic [2:0] idx);
    return (idx < NUM_REGS) ? gpr[idx] : 8'h00;
  endfunction

  // Write a register; drop writes past the register file
  function automatic logic write_gpr(input logic [2:0] idx, input logic [7:0] val);
    if (idx < NUM_REGS) begin
      gpr[idx] = val;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Charge a memory access and mark the address as seen
  function automatic logic touch_mem(input logic [MEM_AW-1:0] addr);
    logic hit;
    hit = touched[addr];
    touched[addr] = 1'b1;
    if (hit) begin
      n_cycles = n_cycles + 32'(hit_cost);
      n_hits   = n_hits + 1;
    end else begin
      n_cycles = n_cycles + 32'(miss_cost);
    end
    n_ldst = n_ldst + 1;
    return hit;
  endfunction

  // Execute one instruction on the predicted state and form its result
  function automatic tie_out_t execute_instr(input tie_in_t req);
    tie_out_t          res;
    logic [7:0]        val;
    logic [MEM_AW-1:0] addr;
    res = '0;
    if (req.op <= OP_ST) n_instr = n_instr + 1;
    if (req.op <= OP_JMP) n_cycles = n_cycles + 1;
    case (req.op)
      OP_MOV: begin
        if (write_gpr(req.dest_reg, req.immediate)) res.written_value = req.immediate;
      end
      OP_ADD: begin
        val = read_gpr(req.dest_reg) +
              (req.use_immediate ? req.immediate : read_gpr(req.src_reg));
        if (write_gpr(req.dest_reg, val)) res.written_value = val;
      end
      OP_CMP: begin
        eq_flag = (read_gpr(req.dest_reg) == read_gpr(req.src_reg));
      end
      OP_JE: begin
        if (eq_flag) begin
          res.jump_taken  = 1'b1;
          res.jump_target = req.jump_address;
          eq_flag         = 1'b0;
        end
      end
      OP_JMP: begin
        res.jump_taken  = 1'b1;
        res.jump_target = req.jump_address;
      end
      OP_LD: begin
        addr        = MEM_AW'(read_gpr(req.src_reg) % MEM_DEPTH);
        val         = dmem[addr];
        res.mem_hit = touch_mem(addr);
        if (write_gpr(req.dest_reg, val)) res.written_value = val;
      end
      OP_ST: begin
        addr              = MEM_AW'(read_gpr(req.dest_reg) % MEM_DEPTH);
        val               = read_gpr(req.src_reg);
        dmem[addr]        = val;
        res.mem_hit       = touch_mem(addr);
        res.written_value = val;
      end
      default: ;
    endcase
    res.instr_total      = n_instr;
    res.cycle_total      = n_cycles;
    res.hit_total        = n_hits;
    res.load_store_total = n_ldst;
    return res;
  endfunction

  // Report one field that differs
  task automatic flag_field(input string field, input logic [31:0] exp_val,
                            input logic [31:0] got_val);
    $display("%0t checker: %s mismatch, expected %0h, actual %0h",
             $time, field, exp_val, got_val);
    n_fail++;
  endtask

  // Compare a result against its prediction field by field
  task automatic check_result(input tie_out_t exp_res, input tie_out_t got);
    if (got.jump_taken !== exp_res.jump_taken)
      flag_field("jump_taken", 32'(exp_res.jump_taken), 32'(got.jump_taken));
    if (got.jump_target !== exp_res.jump_target)
      flag_field("jump_target", 32'(exp_res.jump_target), 32'(got.jump_target));
    if (got.mem_hit !== exp_res.mem_hit)
      flag_field("mem_hit", 32'(exp_res.mem_hit), 32'(got.mem_hit));
    if (got.written_value !== exp_res.written_value)
      flag_field("written_value", 32'(unsigned'(exp_res.written_value)),
                 32'(unsigned'(got.written_value)));
    if (got.instr_total !== exp_res.instr_total)
      flag_field("instr_total", exp_res.instr_total, got.instr_total);
    if (got.cycle_total !== exp_res.cycle_total)
      flag_field("cycle_total", exp_res.cycle_total, got.cycle_total);
    if (got.hit_total !== exp_res.hit_total)
      flag_field("hit_total", exp_res.hit_total, got.hit_total);
    if (got.load_store_total !== exp_res.load_store_total)
      flag_field("load_store_total", exp_res.load_store_total, got.load_store_total);
  endtask

  // Track config writes, retire results, predict new requests
  always @(posedge clk_i or negedge rst_ni) begin
    tie_out_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = 8'h00;
      for (int i = 0; i < MEM_DEPTH; i++) begin
        dmem[i]    = 8'h00;
        touched[i] = 1'b0;
      end
      eq_flag   = 1'b0;
      n_instr   = '0;
      n_cycles  = '0;
      n_hits    = '0;
      n_ldst    = '0;
      miss_cost = MISS_CYCLES_RST;
      hit_cost  = HIT_CYCLES_RST;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MISS_CYCLES: miss_cost = cfg_wdata_i;
          CFG_HIT_CYCLES:  hit_cost  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t checker: result with nothing expected, actual %0h",
                   $time, out_data_i);
          n_fail++;
        end else begin
          exp_res = expected_results.pop_front();
          check_result(exp_res, out_data_i);
        end
        n_checked++;
        if (out_data_i.jump_taken === 1'b1) n_taken++;
        if (out_data_i.mem_hit === 1'b1) n_hit_seen++;
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(execute_instr(in_data_i));
    end
    pending_o         <= expected_results.size();
    fail_count_o      <= n_fail;
    results_checked_o <= n_checked;
    jumps_taken_o     <= n_taken;
    mem_hits_o        <= n_hit_seen;
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the tiny ISA execute unit: clock, reset, stimulus and verdict.
module tb_top;
  import tie_pkg::*;

  localparam logic [2:0] OP_UNKNOWN = 3'd7;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int NUM_PHASES = 5;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  tie_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  tie_out_t              out_data_o;

  int pending;
  int fail_count;
  int results_checked;
  int jumps_taken;
  int mem_hits;

  // Stimulus side controls
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;
  int stall_left    = 0;
  int n_sent        = 0;

  tiny_isa_execute_unit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  tie_exec_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_data_i         (in_data_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_i        (out_data_o),
    .pending_o         (pending),
    .fail_count_o      (fail_count),
    .results_checked_o (results_checked),
    .jumps_taken_o     (jumps_taken),
    .mem_hits_o        (mem_hits)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the unit hangs
  initial begin
    #200000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready_i <= 1'b1;
    end else if (hold_done_cnt != hold_req_cnt) begin
      hold_done_cnt <= hold_done_cnt + 1;
      out_ready_i   <= 1'b0;
      stall_left    <= LONG_HOLD_CYCLES;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(1, 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic tie_in_t make_instr(input logic [2:0] op, input logic [2:0] rd,
                                         input logic [2:0] rs, input logic ui,
                                         input logic [7:0] imm, input logic [7:0] ja);
    tie_in_t instr;
    instr.op            = op;
    instr.dest_reg      = rd;
    instr.src_reg       = rs;
    instr.use_immediate = ui;
    instr.immediate     = imm;
    instr.jump_address  = ja;
    return instr;
  endfunction

  // Random instruction, weighted toward memory traffic and compare/branch pairs
  function automatic tie_in_t random_instr();
    int         pick;
    logic [2:0] op;
    logic [2:0] rd;
    logic [2:0] rs;
    logic [7:0] imm;
    pick = $urandom_range(0, 99);
    if (pick < 14)      op = OP_MOV;
    else if (pick < 28) op = OP_ADD;
    else if (pick < 42) op = OP_CMP;
    else if (pick < 56) op = OP_JE;
    else if (pick < 62) op = OP_JMP;
    else if (pick < 78) op = OP_LD;
    else if (pick < 94) op = OP_ST;
    else                op = OP_UNKNOWN;
    rd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    rs = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if (op == OP_CMP && $urandom_range(0, 4) < 2) rs = rd;
    // Small values keep addresses close together so repeats hit
    imm = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    return make_instr(op, rd, rs, 1'($urandom_range(0, 1)), imm, 8'($urandom_range(0, 255)));
  endfunction

  // Offer one request, with an optional idle burst first, and wait for acceptance
  task automatic issue_instr(input tie_in_t instr);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= instr;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] miss_set [NUM_PHASES];
    logic [7:0] hit_set  [NUM_PHASES];
    int         n_items;

    miss_set = '{8'd0, 8'd255, 8'd255, 8'($urandom_range(0, 255)), 8'd1};
    hit_set  = '{8'd0, 8'd255, 8'd0, 8'($urandom_range(0, 255)), 8'd254};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset costs
    issue_instr(make_instr(OP_MOV, 3'd0, 3'd0, 1'b0, 8'h80, 8'h00));
    issue_instr(make_instr(OP_MOV, 3'd1, 3'd0, 1'b0, 8'h7f, 8'h00));
    issue_instr(make_instr(OP_MOV, 3'd6, 3'd0, 1'b0, 8'h05, 8'h00));
    issue_instr(make_instr(OP_MOV, 3'd7, 3'd0, 1'b1, 8'hff, 8'hff));
    issue_instr(make_instr(OP_ADD, 3'd1, 3'd7, 1'b1, 8'h01, 8'h00));
    issue_instr(make_instr(OP_ADD, 3'd0, 3'd1, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_ADD, 3'd2, 3'd7, 1'b0, 8'h7f, 8'h00));
    issue_instr(make_instr(OP_ADD, 3'd6, 3'd1, 1'b1, 8'h03, 8'h00));
    issue_instr(make_instr(OP_CMP, 3'd0, 3'd2, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_JE,  3'd0, 3'd0, 1'b0, 8'h00, 8'hff));
    issue_instr(make_instr(OP_JE,  3'd0, 3'd0, 1'b0, 8'h00, 8'h11));
    issue_instr(make_instr(OP_CMP, 3'd3, 3'd6, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_JMP, 3'd7, 3'd7, 1'b1, 8'hff, 8'h00));
    // Address zero: first a miss, then hits
    issue_instr(make_instr(OP_ST,  3'd0, 3'd1, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_LD,  3'd3, 3'd0, 1'b0, 8'h00, 8'h00));
    // Register value above 127 used as an unsigned address
    issue_instr(make_instr(OP_ST,  3'd1, 3'd1, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_LD,  3'd4, 3'd1, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_LD,  3'd5, 3'd6, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_ST,  3'd7, 3'd7, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_LD,  3'd7, 3'd1, 1'b0, 8'h00, 8'h00));
    issue_instr(make_instr(OP_UNKNOWN, 3'd5, 3'd2, 1'b1, 8'h55, 8'haa));
    drain_results();

    // Random phases, each with its own access costs
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_MISS_CYCLES, miss_set[p]);
      write_cfg(CFG_HIT_CYCLES, hit_set[p]);
      tx_idle_on  = (p != NUM_PHASES - 1);
      rx_idle_on <= (p != NUM_PHASES - 1);
      n_items = 80;
      if (p == 1) begin
        // Hold off the result side and keep offering until the input stalls
        hold_req_cnt <= hold_req_cnt + 1;
        tx_idle_on = 1'b0;
        for (int i = 0; i < 16; i++) issue_instr(random_instr());
        tx_idle_on = 1'b1;
        n_items = 64;
      end
      for (int i = 0; i < n_items; i++) issue_instr(random_instr());
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    $display("Run covered %0d instructions under %0d cost settings plus reset costs.",
             n_sent, NUM_PHASES);
    $display("Checked %0d results: %0d jumps taken, %0d memory hits.",
             results_checked, jumps_taken, mem_hits);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### files.f
src/tie_pkg.sv
src/tie_front.sv
src/tie_queue.sv
src/tie_back.sv
src/tiny_isa_execute_unit_top.sv
src/tie_checker.sv
tb/sv/tie_exec_checker.sv
tb/sv/tb_top.sv
